// ===== design/smt_pkg.sv =====
// Shared types and constants for the stereo match triangulator.
`default_nettype none
package smt_pkg;

	// Field widths
	localparam int unsigned COORD_W  = 16;
	localparam int unsigned BASE_W   = 24;
	localparam int unsigned PROD_W   = BASE_W + COORD_W;
	localparam int unsigned QUOT_W   = 32;
	localparam int unsigned BASE_FRAC_BITS = 8;

	// Default parameter values
	localparam int unsigned COORD_FRAC_BITS_DEF = 4;
	localparam int unsigned DEPTH_FRAC_BITS_DEF = 8;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_BASELINE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FOCAL     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_TOL   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISP  = 3'd5;

	// Divider lanes
	localparam int unsigned LANES  = 3;
	localparam int unsigned LANE_Z = 0;
	localparam int unsigned LANE_X = 1;
	localparam int unsigned LANE_Y = 2;

	// Saturation limits
	localparam logic [QUOT_W-1:0] SAT_U   = 32'hFFFF_FFFF;
	localparam logic [QUOT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [QUOT_W-1:0] SAT_NEG = 32'h8000_0000;

	// One divider lane: partial remainder and dividend/quotient shift word
	typedef struct packed {
		logic [COORD_W-1:0] rem;
		logic [QUOT_W-1:0]  acc;
		logic               ovf;
		logic               neg;
	} div_lane_t;

	// One item travelling down the divider chain
	typedef struct packed {
		logic                        row_ok;
		logic                        pt_ok;
		logic [COORD_W-1:0]          disp;
		div_lane_t [LANES-1:0]       lane;
	} div_item_t;

	function automatic logic [COORD_W-1:0] abs_diff(
		input logic [COORD_W-1:0] a,
		input logic [COORD_W-1:0] b
	);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

endpackage
`default_nettype wire

// ===== design/smt_front.sv =====
// Front stages: row and disparity checks, products, divider set-up.
`default_nettype none
module smt_front #(
	parameter int unsigned DEPTH_FRAC_BITS = smt_pkg::DEPTH_FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          vld_i,
	input  wire logic [smt_pkg::COORD_W-1:0]   left_x,
	input  wire logic [smt_pkg::COORD_W-1:0]   left_y,
	input  wire logic [smt_pkg::COORD_W-1:0]   right_x,
	input  wire logic [smt_pkg::COORD_W-1:0]   right_y,
	input  wire logic [smt_pkg::BASE_W-1:0]    baseline_q,
	input  wire logic [smt_pkg::COORD_W-1:0]   focal_q,
	input  wire logic [smt_pkg::COORD_W-1:0]   cx_q,
	input  wire logic [smt_pkg::COORD_W-1:0]   cy_q,
	input  wire logic [smt_pkg::COORD_W-1:0]   row_tol_q,
	input  wire logic [smt_pkg::COORD_W-1:0]   min_disp_q,
	output logic                               vld_o,
	output smt_pkg::div_item_t                 item_o
);
	import smt_pkg::*;

	localparam int unsigned NW = PROD_W + DEPTH_FRAC_BITS;
	localparam int unsigned HW = NW - QUOT_W;
	localparam int unsigned CW = (HW > COORD_W) ? HW : COORD_W;

	logic                vld_s1, vld_s2, vld_s3;
	logic                row_ok_s1, pt_ok_s1, neg_x_s1, neg_y_s1;
	logic [COORD_W-1:0]  disp_s1, mag_x_s1, mag_y_s1;
	logic                row_ok_s2, pt_ok_s2, neg_x_s2, neg_y_s2;
	logic [COORD_W-1:0]  disp_s2;
	logic [PROD_W-1:0]   prod_s2 [LANES];
	div_item_t           item_s3;
	logic [COORD_W-1:0]  disp_c;
	logic                row_ok_c;

	assign disp_c   = abs_diff(left_x, right_x);
	assign row_ok_c = abs_diff(left_y, right_y) < row_tol_q;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Stage 1: compares and magnitudes
	always_ff @(posedge clk) begin
		if (en) begin
			row_ok_s1 <= row_ok_c;
			pt_ok_s1  <= row_ok_c && (disp_c > min_disp_q);
			disp_s1   <= disp_c;
			mag_x_s1  <= abs_diff(left_x, cx_q);
			neg_x_s1  <= left_x < cx_q;
			mag_y_s1  <= abs_diff(left_y, cy_q);
			neg_y_s1  <= left_y < cy_q;
		end
	end

	// Stage 2: products
	always_ff @(posedge clk) begin
		if (en) begin
			row_ok_s2       <= row_ok_s1;
			pt_ok_s2        <= pt_ok_s1;
			disp_s2         <= disp_s1;
			neg_x_s2        <= neg_x_s1;
			neg_y_s2        <= neg_y_s1;
			prod_s2[LANE_Z] <= PROD_W'(baseline_q) * PROD_W'(focal_q);
			prod_s2[LANE_X] <= PROD_W'(baseline_q) * PROD_W'(mag_x_s1);
			prod_s2[LANE_Y] <= PROD_W'(baseline_q) * PROD_W'(mag_y_s1);
		end
	end

	// Stage 3: scale dividend, overflow check, seed remainder
	always_ff @(posedge clk) begin
		if (en) begin
			item_s3.row_ok <= row_ok_s2;
			item_s3.pt_ok  <= pt_ok_s2;
			item_s3.disp   <= disp_s2;
			for (int l = 0; l < LANES; l++) begin
				logic [NW-1:0] num;
				logic [HW-1:0] hi;
				num = (NW'(prod_s2[l]) << DEPTH_FRAC_BITS) >> BASE_FRAC_BITS;
				hi  = num[NW-1:QUOT_W];
				item_s3.lane[l].ovf <= CW'(hi) >= CW'(disp_s2);
				item_s3.lane[l].rem <= COORD_W'(hi);
				item_s3.lane[l].acc <= num[QUOT_W-1:0];
			end
			item_s3.lane[LANE_Z].neg <= 1'b0;
			item_s3.lane[LANE_X].neg <= neg_x_s2;
			item_s3.lane[LANE_Y].neg <= neg_y_s2;
		end
	end

	assign vld_o  = vld_s3;
	assign item_o = item_s3;

endmodule
`default_nettype wire

// ===== design/smt_div_cell.sv =====
// One restoring-division cell: one quotient bit per lane per cycle while en is high.
`default_nettype none
module smt_div_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               vld_i,
	input  wire smt_pkg::div_item_t item_i,
	output logic                    vld_o,
	output smt_pkg::div_item_t      item_o
);
	import smt_pkg::*;

	logic      vld_q;
	div_item_t item_q;
	div_item_t nxt;

	// Trial subtract and shift
	always_comb begin
		logic [COORD_W:0] t;
		logic             ge;
		nxt = item_i;
		for (int l = 0; l < LANES; l++) begin
			t  = {item_i.lane[l].rem, item_i.lane[l].acc[QUOT_W-1]};
			ge = t >= {1'b0, item_i.disp};
			nxt.lane[l].rem = ge ? COORD_W'(t - {1'b0, item_i.disp}) : t[COORD_W-1:0];
			nxt.lane[l].acc = {item_i.lane[l].acc[QUOT_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_q <= nxt;
		end
	end

	assign vld_o  = vld_q;
	assign item_o = item_q;

endmodule
`default_nettype wire

// ===== design/smt_back.sv =====
// Output stage: saturation, sign and result register.
`default_nettype none
module smt_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               vld_i,
	input  wire smt_pkg::div_item_t item_i,
	output logic                    out_valid,
	output logic                    row_match,
	output logic                    point_valid,
	output logic signed [31:0]      point_x,
	output logic signed [31:0]      point_y,
	output logic [31:0]             point_z
);
	import smt_pkg::*;

	logic [QUOT_W-1:0] z_c, x_c, y_c;

	function automatic logic [QUOT_W-1:0] lat_sat(input div_lane_t ln);
		if (!ln.neg) begin
			return (ln.ovf || ln.acc > SAT_POS) ? SAT_POS : ln.acc;
		end
		return (ln.ovf || ln.acc >= SAT_NEG) ? SAT_NEG : (QUOT_W'(0) - ln.acc);
	endfunction

	// Saturate and zero invalid points
	always_comb begin
		z_c = '0;
		x_c = '0;
		y_c = '0;
		if (item_i.pt_ok) begin
			z_c = item_i.lane[LANE_Z].ovf ? SAT_U : item_i.lane[LANE_Z].acc;
			x_c = lat_sat(item_i.lane[LANE_X]);
			y_c = lat_sat(item_i.lane[LANE_Y]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			row_match   <= item_i.row_ok;
			point_valid <= item_i.pt_ok;
			point_x     <= signed'(x_c);
			point_y     <= signed'(y_c);
			point_z     <= z_c;
		end
	end

endmodule
`default_nettype wire

// ===== design/stereo_match_triangulator_core.sv =====
// Each accepted item passes 3 set-up stages, 32 divider cells and 1 output
// register on its way to the result. Throughput: one item per cycle; the
// whole pipeline holds while a result waits under out_stall.
// Latency is set by the 32-cell restoring divider chain, one quotient bit per cell.
// Reset clears all valid bits and loads register defaults (row tolerance 4 px,
// minimum disparity 10 px, others zero).
`default_nettype none
module stereo_match_triangulator_core #(
	parameter int unsigned COORD_FRAC_BITS = smt_pkg::COORD_FRAC_BITS_DEF,
	parameter int unsigned DEPTH_FRAC_BITS = smt_pkg::DEPTH_FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [15:0]                   left_x,
	input  wire logic [15:0]                   left_y,
	input  wire logic [15:0]                   right_x,
	input  wire logic [15:0]                   right_y,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               row_match,
	output logic                               point_valid,
	output logic signed [31:0]                 point_x,
	output logic signed [31:0]                 point_y,
	output logic [31:0]                        point_z,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [smt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [smt_pkg::BASE_W-1:0]    cfg_data
);
	import smt_pkg::*;

	localparam logic [COORD_W-1:0] ROW_TOL_RST  = COORD_W'(4 << COORD_FRAC_BITS);
	localparam logic [COORD_W-1:0] MIN_DISP_RST = COORD_W'(10 << COORD_FRAC_BITS);

	logic [BASE_W-1:0]  baseline_q;
	logic [COORD_W-1:0] focal_q, cx_q, cy_q, row_tol_q, min_disp_q;
	logic               en;
	logic               vld_c  [QUOT_W+1];
	div_item_t          item_c [QUOT_W+1];

	// Pipeline advances unless a result is held
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baseline_q <= '0;
			focal_q    <= '0;
			cx_q       <= '0;
			cy_q       <= '0;
			row_tol_q  <= ROW_TOL_RST;
			min_disp_q <= MIN_DISP_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BASELINE: baseline_q <= cfg_data;
				CFG_FOCAL:    focal_q    <= cfg_data[COORD_W-1:0];
				CFG_CENTER_X: cx_q       <= cfg_data[COORD_W-1:0];
				CFG_CENTER_Y: cy_q       <= cfg_data[COORD_W-1:0];
				CFG_ROW_TOL:  row_tol_q  <= cfg_data[COORD_W-1:0];
				CFG_MIN_DISP: min_disp_q <= cfg_data[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	smt_front #(
		.DEPTH_FRAC_BITS(DEPTH_FRAC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.vld_i      (in_valid),
		.left_x     (left_x),
		.left_y     (left_y),
		.right_x    (right_x),
		.right_y    (right_y),
		.baseline_q (baseline_q),
		.focal_q    (focal_q),
		.cx_q       (cx_q),
		.cy_q       (cy_q),
		.row_tol_q  (row_tol_q),
		.min_disp_q (min_disp_q),
		.vld_o      (vld_c[0]),
		.item_o     (item_c[0])
	);

	// Divider chain, one quotient bit per cell
	for (genvar i = 0; i < QUOT_W; i++) begin : g_cell
		smt_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (vld_c[i]),
			.item_i (item_c[i]),
			.vld_o  (vld_c[i+1]),
			.item_o (item_c[i+1])
		);
	end

	smt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.vld_i       (vld_c[QUOT_W]),
		.item_i      (item_c[QUOT_W]),
		.out_valid   (out_valid),
		.row_match   (row_match),
		.point_valid (point_valid),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_z     (point_z)
	);

`ifndef SYNTHESIS
	a_pt_needs_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!point_valid || row_match))
		else $error("point valid without row match");
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !point_valid) |-> (point_x == 0 && point_y == 0 && point_z == 0))
		else $error("invalid point with non-zero coordinates");
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held result");
	a_hold_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (vld_c[QUOT_W] == $past(vld_c[QUOT_W])))
		else $error("divider chain moved while result held");
`endif

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Testbench for stereo_match_triangulator_core: queued random and directed match pairs, bit-exact prediction.
`default_nettype none
module tb;
	import smt_pkg::*;

	typedef struct {
		logic [15:0] lx, ly, rx, ry;
	} pair_t;

	typedef struct {
		logic               row_ok;
		logic               pt_ok;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic [31:0]        pz;
	} point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [15:0] left_x = '0, left_y = '0, right_x = '0, right_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic row_match, point_valid;
	logic signed [31:0] point_x, point_y;
	logic [31:0] point_z;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BASE_W-1:0] cfg_data = '0;

	// shadow copy of the block's registers
	logic [23:0] sh_base;
	logic [15:0] sh_focal, sh_cx, sh_cy, sh_tol, sh_mind;

	pair_t  pair_q[$];
	point_t point_q[$];
	int     errors = 0;
	bit     quiet = 1'b0;
	int     in_gap = 0, out_gap = 0;

	stereo_match_triangulator_core dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("tb failed");
		$finish;
	end

	// (pos - centre) * baseline * 256 / den, signed and saturated
	function automatic logic [31:0] lateral_coord(logic [15:0] pos, logic [15:0] ctr,
			logic [63:0] den);
		logic [63:0] mag, q;
		mag = (pos >= ctr) ? 64'(pos - ctr) : 64'(ctr - pos);
		q = ((mag * sh_base) << 8) / den;
		if (pos >= ctr)
			return (q > 64'h7FFF_FFFF) ? SAT_POS : q[31:0];
		if (q >= 64'h8000_0000)
			return SAT_NEG;
		return 32'(-q);
	endfunction

	function automatic point_t triangulate(pair_t p);
		point_t r;
		logic [15:0] dy, dx;
		logic [63:0] den, z;
		dy = (p.ly >= p.ry) ? p.ly - p.ry : p.ry - p.ly;
		dx = (p.lx >= p.rx) ? p.lx - p.rx : p.rx - p.lx;
		r.row_ok = dy < sh_tol;
		r.pt_ok  = r.row_ok && (dx > sh_mind);
		r.px = '0;
		r.py = '0;
		r.pz = '0;
		if (r.pt_ok) begin
			den = 64'(dx) << 8;
			z = ((64'(sh_base) * sh_focal) << 8) / den;
			r.pz = (z > 64'hFFFF_FFFF) ? SAT_U : z[31:0];
			r.px = lateral_coord(p.lx, sh_cx, den);
			r.py = lateral_coord(p.ly, sh_cy, den);
		end
		return r;
	endfunction

	// driver: feeds pairs from the queue, random idle bursts
	always @(posedge clk) begin
		logic nv;
		pair_t p;
		nv = in_valid;
		if (in_valid && !in_stall) begin
			point_q = {point_q, triangulate('{left_x, left_y, right_x, right_y})};
			nv = 1'b0;
		end
		if (!nv && arst_n) begin
			if (in_gap > 0)
				in_gap--;
			else if (pair_q.size() > 0) begin
				p = pair_q.pop_front();
				left_x  <= p.lx;
				left_y  <= p.ly;
				right_x <= p.rx;
				right_y <= p.ry;
				nv = 1'b1;
				if (!quiet && $urandom_range(0, 9) == 0)
					in_gap = $urandom_range(1, 14);
			end
		end
		in_valid <= nv;
	end

	// monitor: random stall bursts, field-by-field compare
	always @(posedge clk) begin
		point_t e;
		if (out_valid && !out_stall) begin
			if (point_q.size() == 0) begin
				$display("%0t: unexpected item row=%b valid=%b x=%h y=%h z=%h", $time,
					row_match, point_valid, point_x, point_y, point_z);
				errors++;
			end else begin
				e = point_q.pop_front();
				if (row_match !== e.row_ok) begin
					$display("%0t: row_match exp %b got %b", $time, e.row_ok, row_match);
					errors++;
				end
				if (point_valid !== e.pt_ok) begin
					$display("%0t: point_valid exp %b got %b", $time, e.pt_ok, point_valid);
					errors++;
				end
				if (point_x !== e.px) begin
					$display("%0t: point_x exp %h got %h", $time, e.px, point_x);
					errors++;
				end
				if (point_y !== e.py) begin
					$display("%0t: point_y exp %h got %h", $time, e.py, point_y);
					errors++;
				end
				if (point_z !== e.pz) begin
					$display("%0t: point_z exp %h got %h", $time, e.pz, point_z);
					errors++;
				end
			end
		end
		if (out_gap > 0) begin
			out_gap--;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			out_gap = $urandom_range(0, 13);
			out_stall <= 1'b1;
		end else
			out_stall <= 1'b0;
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_BASELINE: sh_base  = val;
			CFG_FOCAL:    sh_focal = val[15:0];
			CFG_CENTER_X: sh_cx    = val[15:0];
			CFG_CENTER_Y: sh_cy    = val[15:0];
			CFG_ROW_TOL:  sh_tol   = val[15:0];
			CFG_MIN_DISP: sh_mind  = val[15:0];
			default: ;
		endcase
	endtask

	task automatic set_all(logic [23:0] b, logic [15:0] f, logic [15:0] cx, logic [15:0] cy,
			logic [15:0] tol, logic [15:0] md);
		write_reg(CFG_BASELINE, b);
		write_reg(CFG_FOCAL, 24'(f));
		write_reg(CFG_CENTER_X, 24'(cx));
		write_reg(CFG_CENTER_Y, 24'(cy));
		write_reg(CFG_ROW_TOL, 24'(tol));
		write_reg(CFG_MIN_DISP, 24'(md));
	endtask

	// wait for the pipeline to drain before touching registers again;
	// checked mid-cycle so the driver's updates have settled
	task automatic drain();
		while (pair_q.size() > 0 || in_valid || point_q.size() > 0)
			@(negedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic add(logic [15:0] lx, logic [15:0] ly, logic [15:0] rx, logic [15:0] ry);
		pair_q = {pair_q, pair_t'{lx, ly, rx, ry}};
	endtask

	// mostly well-formed matches, the rest noise
	task automatic add_random(int n);
		int d, dy;
		logic [15:0] lx, ly;
		repeat (n) begin
			lx = 16'($urandom);
			ly = 16'($urandom);
			if ($urandom_range(0, 4) == 0 || sh_mind >= 16'hFFF0)
				add(lx, ly, 16'($urandom), 16'($urandom));
			else begin
				d = $urandom_range(int'(sh_mind) + 1,
					($urandom_range(0, 3) == 0) ? 65535 : int'(sh_mind) + 2000);
				if (d > 65535) d = 65535;
				dy = (sh_tol == 0) ? 0 : $urandom_range(0, int'(sh_tol) - 1);
				if ($urandom_range(0, 9) == 0) dy = int'(sh_tol);
				if (lx < d) lx = 16'(d + $urandom_range(0, 65535 - d));
				if (int'(ly) + dy > 65535) ly = 16'(65535 - dy);
				if ($urandom_range(0, 1))
					add(lx, ly, 16'(lx - d), 16'(ly + dy));
				else if (int'(lx) + d <= 65535)
					add(16'(lx - d), 16'(ly + dy), lx, ly);
				else
					add(lx, 16'(ly + dy), 16'(lx - d), ly);
			end
		end
	endtask

	initial begin
		sh_base = '0; sh_focal = '0; sh_cx = '0; sh_cy = '0;
		sh_tol = 16'd64; sh_mind = 16'd160;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults after reset: tolerance and minimum disparity edges, zero baseline
		add(16'd0, 16'd0, 16'd0, 16'd0);
		add(16'd500, 16'd100, 16'd340, 16'd100);
		add(16'd500, 16'd100, 16'd339, 16'd163);
		add(16'd500, 16'd100, 16'd339, 16'd164);
		add(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
		add_random(20);
		drain();

		// typical camera, directed signs and magnitudes
		set_all(24'h000100, 16'h0800, 16'd5120, 16'd3840, 16'd64, 16'd160);
		add(16'd8000, 16'd3840, 16'd7000, 16'd3850);
		add(16'd1000, 16'd1000, 16'd2000, 16'd1000);
		add(16'd5120, 16'd3840, 16'd5281, 16'd3840);
		add(16'hFFFF, 16'hFFFF, 16'hFF00, 16'hFFC2);
		add(16'd0, 16'd0, 16'hFFFF, 16'd63);
		add_random(300);
		drain();

		// extremes: largest baseline and focal, smallest disparity, saturation
		set_all(24'hFFFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
		add(16'd1, 16'd0, 16'd0, 16'd0);
		add(16'hFFFF, 16'hFFFF, 16'hFFFE, 16'd0);
		add(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
		add(16'd7, 16'd9, 16'd7, 16'd9);
		add_random(200);
		drain();

		// zero focal length: depth zero, lateral still computed
		write_reg(CFG_FOCAL, 24'h0);
		write_reg(CFG_MIN_DISP, 24'd16);
		add(16'd4000, 16'd3000, 16'd3000, 16'd3000);
		add_random(150);
		drain();

		// nothing can match or triangulate
		set_all(24'h123456, 16'h0400, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
		add(16'hFFFF, 16'd0, 16'd0, 16'd0);
		add_random(100);
		drain();

		// random settings
		repeat (6) begin
			set_all(24'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				$urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 256)),
				$urandom_range(0, 1) ? 16'($urandom_range(0, 2000)) : 16'($urandom));
			add_random(110);
			drain();
		end

		// last stretch without idling
		quiet = 1'b1;
		set_all(24'h000A80, 16'h0C00, 16'd5000, 16'd4000, 16'd32, 16'd8);
		add_random(120);
		drain();

		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
design/smt_pkg.sv
design/smt_front.sv
design/smt_div_cell.sv
design/smt_back.sv
design/stereo_match_triangulator_core.sv
test/tb.sv
